// ----- src/vector_to_pitch_yaw_unit_macros.svh -----
// Assertion macros shared by the checkers of the pitch and yaw unit.
// Depends on nothing; files that assert include it by its bare name.
`ifndef VECTOR_TO_PITCH_YAW_UNIT_MACROS_SVH
`define VECTOR_TO_PITCH_YAW_UNIT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define V2PY_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vector_to_pitch_yaw_unit check failed");

// Concurrent check that holds at every edge, reset included.
`define V2PY_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vector_to_pitch_yaw_unit check failed");

`endif

// ----- src/v2py_pkg.sv -----
// Package of the pitch and yaw unit: widths, angle constants, types.
// Depends on nothing; used by every module of the unit.
`default_nettype none

package v2py_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int ROTATION_STAGES = 16;
  localparam int TABLE_LEN       = 24;

  localparam int D_W        = COORD_WIDTH + 1;
  localparam int MAG_W      = (COORD_WIDTH > 24) ? 24 : COORD_WIDTH;
  localparam int MAG_SHIFT  = (COORD_WIDTH > 24) ? COORD_WIDTH - 24 : 0;
  localparam int ROOT_W     = MAG_W + 1;
  localparam int SQ_W       = 2 * ROOT_W + 1;
  localparam int ROOT_IDX_W = $clog2(ROOT_W);
  localparam int PRE_SHIFT  = 58 - COORD_WIDTH;
  localparam int CR_W       = 62;
  localparam int ANG_W      = 31;
  localparam int STG_W      = $clog2(TABLE_LEN);
  localparam int UNIT_W     = ANG_W + 1 - 13;
  localparam int PITCH_W    = 15;
  localparam int YAW_W      = 16;
  localparam int LATENCY    = ROOT_W + ROTATION_STAGES + 5;

  localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(180 * 1048576);
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(90 * 1048576);
  localparam logic signed [UNIT_W-1:0] YAW_MOD     = UNIT_W'(46080);
  localparam logic signed [UNIT_W-1:0] PITCH_LIMIT = UNIT_W'(11520);

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [CR_W-1:0]  x;
    logic signed [CR_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
    logic                    bypass;
  } cordic_t;

  // Arctangent of two to the minus i, in units of 2^-20 degree.
  function automatic logic signed [ANG_W-1:0] step_angle(input logic [STG_W-1:0] i);
    logic signed [ANG_W-1:0] a;
    case (i)
      5'd0:    a = ANG_W'(47185920);
      5'd1:    a = ANG_W'(27855475);
      5'd2:    a = ANG_W'(14718068);
      5'd3:    a = ANG_W'(7471121);
      5'd4:    a = ANG_W'(3750058);
      5'd5:    a = ANG_W'(1876857);
      5'd6:    a = ANG_W'(938658);
      5'd7:    a = ANG_W'(469357);
      5'd8:    a = ANG_W'(234682);
      5'd9:    a = ANG_W'(117342);
      5'd10:   a = ANG_W'(58671);
      5'd11:   a = ANG_W'(29335);
      5'd12:   a = ANG_W'(14668);
      5'd13:   a = ANG_W'(7334);
      5'd14:   a = ANG_W'(3667);
      5'd15:   a = ANG_W'(1833);
      5'd16:   a = ANG_W'(917);
      5'd17:   a = ANG_W'(458);
      5'd18:   a = ANG_W'(229);
      5'd19:   a = ANG_W'(115);
      5'd20:   a = ANG_W'(57);
      5'd21:   a = ANG_W'(29);
      5'd22:   a = ANG_W'(14);
      5'd23:   a = ANG_W'(7);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- src/v2py_sqrt_cell.sv -----
// One cell of the pipelined integer square root: settles one root bit.
// Depends on v2py_pkg.
`default_nettype none

module v2py_sqrt_cell (
  input  wire logic                             clk_i,
  input  wire logic [v2py_pkg::ROOT_IDX_W-1:0]  idx_i,
  input  wire v2py_pkg::sqrt_t                  data_i,
  output v2py_pkg::sqrt_t                       data_o
);

  logic [v2py_pkg::SQ_W-1:0] bitv;
  logic [v2py_pkg::SQ_W-1:0] trial;
  v2py_pkg::sqrt_t           data_d;
  v2py_pkg::sqrt_t           data_q;

  always_comb begin
    bitv  = v2py_pkg::SQ_W'(1) << {idx_i, 1'b0};
    trial = data_i.res + bitv;
    if (data_i.rem >= trial) begin
      data_d.rem = data_i.rem - trial;
      data_d.res = (data_i.res >> 1) + bitv;
    end else begin
      data_d.rem = data_i.rem;
      data_d.res = data_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- src/v2py_cordic_cell.sv -----
// One vectoring rotation cell of the arctangent chain.
// Depends on v2py_pkg for the data type and the angle table.
`default_nettype none

module v2py_cordic_cell (
  input  wire logic                        clk_i,
  input  wire logic [v2py_pkg::STG_W-1:0]  stage_i,
  input  wire v2py_pkg::cordic_t           data_i,
  output v2py_pkg::cordic_t                data_o
);

  logic signed [v2py_pkg::CR_W-1:0] xs;
  logic signed [v2py_pkg::CR_W-1:0] ys;
  logic signed [v2py_pkg::ANG_W-1:0] step;
  v2py_pkg::cordic_t data_d;
  v2py_pkg::cordic_t data_q;

  always_comb begin
    xs     = data_i.x >>> stage_i;
    ys     = data_i.y >>> stage_i;
    step   = v2py_pkg::step_angle(stage_i);
    data_d = data_i;
    if (data_i.y[v2py_pkg::CR_W-1]) begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      if (!data_i.bypass) begin
        data_d.ang = data_i.ang - step;
      end
    end else begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      if (!data_i.bypass) begin
        data_d.ang = data_i.ang + step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- src/vector_to_pitch_yaw_unit.sv -----
// done_o marks each result and follows start_i through the valid pipeline.
// Throughput: one point pair per cycle; busy_o stays low and results always
// leave on the strobe, since the receiver cannot stall.
// The square root row (one cell per root bit) and the two rotation rows set
// the depth. Reset clears only the valid pipeline; data registers are free.
// Depends on v2py_pkg, v2py_sqrt_cell and v2py_cordic_cell.
`default_nettype none

module vector_to_pitch_yaw_unit (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      start_i,
  input  wire logic signed [v2py_pkg::COORD_WIDTH-1:0]   observer_x_i,
  input  wire logic signed [v2py_pkg::COORD_WIDTH-1:0]   observer_y_i,
  input  wire logic signed [v2py_pkg::COORD_WIDTH-1:0]   observer_z_i,
  input  wire logic signed [v2py_pkg::COORD_WIDTH-1:0]   target_x_i,
  input  wire logic signed [v2py_pkg::COORD_WIDTH-1:0]   target_y_i,
  input  wire logic signed [v2py_pkg::COORD_WIDTH-1:0]   target_z_i,
  output logic                                           busy_o,
  output logic                                           done_o,
  output logic signed [v2py_pkg::PITCH_W-1:0]            pitch_angle_o,
  output logic        [v2py_pkg::YAW_W-1:0]              yaw_angle_o
);

  localparam int DW = v2py_pkg::D_W;
  localparam int MW = v2py_pkg::MAG_W;
  localparam int RW = v2py_pkg::ROOT_W;
  localparam int RS = v2py_pkg::ROTATION_STAGES;
  localparam int LAT = v2py_pkg::LATENCY;
  localparam int CW = v2py_pkg::CR_W;
  localparam int AW = v2py_pkg::ANG_W;
  localparam int UW = v2py_pkg::UNIT_W;

  typedef struct packed {
    logic signed [MW:0]   dzs;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } side_t;

  function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
    logic [DW-1:0] a;
    a = v[DW-1] ? DW'(-v) : DW'(v);
    return MW'(a >> v2py_pkg::MAG_SHIFT);
  endfunction

  // The operands carry one bit more than a difference, so the root of the
  // full length stays positive.
  function automatic v2py_pkg::cordic_t prep(input logic signed [DW:0] x,
                                             input logic signed [DW:0] y);
    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;
    v2py_pkg::cordic_t    c;
    xe = CW'(x);
    ye = CW'(y);
    c.bypass = (x == '0) || (y == '0);
    if (y == '0) begin
      c.ang = x[DW] ? v2py_pkg::HALF_TURN : '0;
    end else if (x == '0) begin
      c.ang = y[DW] ? -v2py_pkg::QUARTER_TURN : v2py_pkg::QUARTER_TURN;
    end else if (x[DW]) begin
      c.ang = y[DW] ? -v2py_pkg::HALF_TURN : v2py_pkg::HALF_TURN;
    end else begin
      c.ang = '0;
    end
    if (x[DW]) begin
      xe = -xe;
      ye = -ye;
    end
    c.x = xe <<< v2py_pkg::PRE_SHIFT;
    c.y = ye <<< v2py_pkg::PRE_SHIFT;
    return c;
  endfunction

  function automatic logic signed [UW-1:0] to_units(input logic signed [AW:0] a);
    logic signed [AW:0] s;
    s = a + (AW + 1)'(4096);
    return UW'(s >>> 13);
  endfunction

  logic [LAT-1:0] vld_q;

  logic signed [DW-1:0] dx_q, dy_q, dz_q;
  logic [MW-1:0] ax, ay, az;
  logic signed [MW:0] azs;
  logic [2*MW-1:0] sqx_q, sqy_q, sqz_q;
  side_t side2_q, side3_q, side2_d;
  logic [v2py_pkg::SQ_W-1:0] sum_q;
  side_t side_q [RW];
  v2py_pkg::sqrt_t sq_chain [RW+1];
  v2py_pkg::cordic_t pre_p_q, pre_y_q;
  v2py_pkg::cordic_t cp [RS+1];
  v2py_pkg::cordic_t cy [RS+1];
  logic signed [UW-1:0] up, uy;
  logic signed [v2py_pkg::PITCH_W-1:0] pitch_d, pitch_q;
  logic [v2py_pkg::YAW_W-1:0] yaw_d, yaw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
    end
  end

  always_comb begin
    ax = mag(dx_q);
    ay = mag(dy_q);
    az = mag(dz_q);
    azs = signed'({1'b0, az});
    side2_d.dzs = dz_q[DW-1] ? -azs : azs;
    side2_d.dx  = dx_q;
    side2_d.dy  = dy_q;
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= DW'(target_x_i) - DW'(observer_x_i);
    dy_q    <= DW'(target_y_i) - DW'(observer_y_i);
    dz_q    <= DW'(target_z_i) - DW'(observer_z_i);
    sqx_q   <= ax * ax;
    sqy_q   <= ay * ay;
    sqz_q   <= az * az;
    side2_q <= side2_d;
    sum_q   <= v2py_pkg::SQ_W'(sqx_q) + v2py_pkg::SQ_W'(sqy_q) + v2py_pkg::SQ_W'(sqz_q);
    side3_q <= side2_q;
    side_q[0] <= side3_q;
    for (int k = 1; k < RW; k++) begin
      side_q[k] <= side_q[k-1];
    end
    pre_p_q <= prep((DW + 1)'({1'b0, sq_chain[RW].res[RW-1:0]}),
                    (DW + 1)'(side_q[RW-1].dzs));
    pre_y_q <= prep((DW + 1)'(side_q[RW-1].dy), (DW + 1)'(side_q[RW-1].dx));
    pitch_q <= pitch_d;
    yaw_q   <= yaw_d;
  end

  assign sq_chain[0].rem = sum_q;
  assign sq_chain[0].res = '0;

  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    v2py_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (v2py_pkg::ROOT_IDX_W'(RW - 1 - g)),
      .data_i (sq_chain[g]),
      .data_o (sq_chain[g+1])
    );
  end

  assign cp[0] = pre_p_q;
  assign cy[0] = pre_y_q;

  for (genvar g = 0; g < RS; g++) begin : g_rot
    v2py_cordic_cell u_pitch (
      .clk_i   (clk_i),
      .stage_i (v2py_pkg::STG_W'(g)),
      .data_i  (cp[g]),
      .data_o  (cp[g+1])
    );
    v2py_cordic_cell u_yaw (
      .clk_i   (clk_i),
      .stage_i (v2py_pkg::STG_W'(g)),
      .data_i  (cy[g]),
      .data_o  (cy[g+1])
    );
  end

  always_comb begin
    up = to_units((AW + 1)'(cp[RS].ang));
    uy = to_units((AW + 1)'(v2py_pkg::HALF_TURN) - (AW + 1)'(cy[RS].ang));
    if (up > v2py_pkg::PITCH_LIMIT) begin
      pitch_d = v2py_pkg::PITCH_W'(v2py_pkg::PITCH_LIMIT);
    end else if (up < -v2py_pkg::PITCH_LIMIT) begin
      pitch_d = v2py_pkg::PITCH_W'(-v2py_pkg::PITCH_LIMIT);
    end else begin
      pitch_d = v2py_pkg::PITCH_W'(up);
    end
    if (uy < 0) begin
      yaw_d = v2py_pkg::YAW_W'(uy + v2py_pkg::YAW_MOD);
    end else if (uy >= v2py_pkg::YAW_MOD) begin
      yaw_d = v2py_pkg::YAW_W'(uy - v2py_pkg::YAW_MOD);
    end else begin
      yaw_d = v2py_pkg::YAW_W'(uy);
    end
  end

  assign busy_o        = 1'b0;
  assign done_o        = vld_q[LAT-1];
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;

endmodule

`default_nettype wire

// ----- src/v2py_checker.sv -----
// Port-level checker of the pitch and yaw unit, bound to the top level.
// Depends on v2py_pkg and the assertion macro header.
`default_nettype none
`include "vector_to_pitch_yaw_unit_macros.svh"

module v2py_checker (
  input wire logic                                     clk_i,
  input wire logic                                     rst_ni,
  input wire logic                                     start_i,
  input wire logic signed [v2py_pkg::COORD_WIDTH-1:0]  observer_x_i,
  input wire logic signed [v2py_pkg::COORD_WIDTH-1:0]  observer_y_i,
  input wire logic signed [v2py_pkg::COORD_WIDTH-1:0]  observer_z_i,
  input wire logic signed [v2py_pkg::COORD_WIDTH-1:0]  target_x_i,
  input wire logic signed [v2py_pkg::COORD_WIDTH-1:0]  target_y_i,
  input wire logic signed [v2py_pkg::COORD_WIDTH-1:0]  target_z_i,
  input wire logic                                     busy_o,
  input wire logic                                     done_o,
  input wire logic signed [v2py_pkg::PITCH_W-1:0]      pitch_angle_o,
  input wire logic        [v2py_pkg::YAW_W-1:0]        yaw_angle_o
);

  `V2PY_ASSERT_ALL(a_never_busy, clk_i, !busy_o)
  `V2PY_ASSERT_RST(a_done_follows, clk_i, rst_ni, (start_i && !busy_o) |-> ##(v2py_pkg::LATENCY) done_o)
  `V2PY_ASSERT_RST(a_no_spurious, clk_i, rst_ni, !(start_i && !busy_o) |-> ##(v2py_pkg::LATENCY) !done_o)
  `V2PY_ASSERT_RST(a_yaw_range, clk_i, rst_ni, done_o |-> (yaw_angle_o < v2py_pkg::YAW_W'(46080)))
  `V2PY_ASSERT_RST(a_pitch_range, clk_i, rst_ni, done_o |-> ((pitch_angle_o <= v2py_pkg::PITCH_W'(11520)) && (pitch_angle_o >= -v2py_pkg::PITCH_W'(11520))))

endmodule

bind vector_to_pitch_yaw_unit v2py_checker u_v2py_checker (.*);

`default_nettype wire
